// File: design/scc_pkg.sv
`timescale 1ns / 1ps
package scc_pkg;

  localparam int unsigned Q_ONE      = 16384;
  localparam int unsigned DIV_STEPS  = 29;
  localparam int unsigned SQRT_STEPS = 15;
  localparam int unsigned NORM_STEPS = 5;

  typedef enum logic [1:0] {
    MODE_NORM   = 2'd0,
    MODE_FREQ   = 2'd1,
    MODE_SIGNED = 2'd2
  } mode_t;

  // per-item control carried down the chain
  typedef struct packed {
    logic       vld;
    logic [1:0] mode;
    logic       neg;
    logic       spec;
    logic       spec_one;
  } ctx_t;

  // square-ratio operands during normalization
  typedef struct packed {
    ctx_t        ctx;
    logic [63:0] a;
    logic [63:0] b;
    logic [31:0] adot;
    logic [32:0] e;
  } norm_t;

  // restoring divider cell state
  typedef struct packed {
    ctx_t        ctx;
    logic [33:0] rem;
    logic [33:0] dvs;
    logic [28:0] bits;
  } div_t;

  // square root cell state
  typedef struct packed {
    ctx_t        ctx;
    logic [28:0] x;
    logic [28:0] res;
    logic [14:0] q2;
  } sq_t;

endpackage

// File: design/scc_front.sv
`timescale 1ns / 1ps
module scc_front import scc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_fire,
  input  logic signed [15:0] left_re,
  input  logic signed [15:0] left_im,
  input  logic signed [15:0] right_re,
  input  logic signed [15:0] right_im,
  input  logic [1:0]         mode,
  output div_t               div_o
);

  // stage 1: partial products
  logic               s1_vld_r;
  logic [1:0]         s1_mode_r;
  logic signed [31:0] ll_r, li_r, rr_r, ri_r, d1_r, d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode_r <= mode;
      ll_r      <= left_re * left_re;
      li_r      <= left_im * left_im;
      rr_r      <= right_re * right_re;
      ri_r      <= right_im * right_im;
      d1_r      <= left_re * right_re;
      d2_r      <= left_im * right_im;
    end
  end

  // stage 2: powers, energy, dot product, special cases
  logic [31:0]        pl_c, pr_c, adot_c;
  logic [32:0]        e_c, ndot_c;
  logic signed [32:0] dot_c;
  ctx_t               ctx2_c;

  always_comb begin
    pl_c   = $unsigned(ll_r) + $unsigned(li_r);
    pr_c   = $unsigned(rr_r) + $unsigned(ri_r);
    e_c    = {1'b0, pl_c} + {1'b0, pr_c};
    dot_c  = {d1_r[31], d1_r} + {d2_r[31], d2_r};
    ndot_c = -dot_c;
    adot_c = dot_c[32] ? ndot_c[31:0] : dot_c[31:0];
    ctx2_c.vld  = s1_vld_r;
    ctx2_c.mode = s1_mode_r;
    ctx2_c.neg  = dot_c[32];
    if (s1_mode_r == MODE_FREQ || s1_mode_r == MODE_SIGNED) begin
      ctx2_c.spec     = (e_c == 33'd0);
      ctx2_c.spec_one = 1'b1;
    end else begin
      ctx2_c.spec     = (pl_c == 32'd0) || (pr_c == 32'd0) || (adot_c == 32'd0);
      ctx2_c.spec_one = (pl_c == 32'd0) || (pr_c == 32'd0);
    end
  end

  ctx_t        ctx2_r;
  logic [31:0] pl_r, pr_r, adot2_r;
  logic [32:0] e2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx2_r.vld <= 1'b0;
    end else if (en) begin
      ctx2_r <= ctx2_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r    <= pl_c;
      pr_r    <= pr_c;
      adot2_r <= adot_c;
      e2_r    <= e_c;
    end
  end

  // stage 3: the two 32x32 products of the square ratio
  logic [31:0] op1_c;
  logic [63:0] m1_c, m2_c;

  always_comb begin
    if (ctx2_r.mode == MODE_FREQ) begin
      op1_c = e2_r[32] ? e2_r[32:1] : e2_r[31:0];
    end else begin
      op1_c = adot2_r;
    end
    m1_c = op1_c * op1_c;
    m2_c = pl_r * pr_r;
  end

  ctx_t        ctx3_r;
  logic [63:0] m1_r, m2_r;
  logic [31:0] adot3_r;
  logic [32:0] e3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx3_r.vld <= 1'b0;
    end else if (en) begin
      ctx3_r <= ctx2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r    <= m1_c;
      m2_r    <= m2_c;
      adot3_r <= adot2_r;
      e3_r    <= e2_r;
    end
  end

  // numerator and denominator per mode
  norm_t norm_s [0:NORM_STEPS];

  always_comb begin
    norm_s[0].ctx  = ctx3_r;
    norm_s[0].adot = adot3_r;
    norm_s[0].e    = e3_r;
    if (ctx3_r.mode == MODE_FREQ) begin
      norm_s[0].a = e3_r[32] ? m2_r : {m2_r[61:0], 2'b00};
      norm_s[0].b = m1_r;
    end else begin
      norm_s[0].a = m1_r;
      norm_s[0].b = m2_r;
    end
  end

  // stages 4..8: bring b below 2^34 by shifts of 16, 8, 4, 2, 1
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int S = 16 >> j;
    norm_t nxt_c;
    norm_t st_r;

    always_comb begin
      nxt_c = norm_s[j];
      if (|norm_s[j].b[63:33+S]) begin
        nxt_c.a = norm_s[j].a >> S;
        nxt_c.b = norm_s[j].b >> S;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r.ctx.vld <= 1'b0;
      end else if (en) begin
        st_r <= nxt_c;
      end
    end

    assign norm_s[j+1] = st_r;
  end

  // stage 9: divider setup
  norm_t       nf;
  logic [33:0] a2_c;
  logic [48:0] num_c;
  div_t        div_nxt;

  always_comb begin
    nf    = norm_s[NORM_STEPS];
    a2_c  = (nf.a > nf.b) ? nf.b[33:0] : nf.a[33:0];
    num_c = {1'b0, nf.adot, 16'd0} + {16'd0, nf.e};
    div_nxt.ctx = nf.ctx;
    if (nf.ctx.mode == MODE_SIGNED) begin
      // dividend (adot*2^16 + e) * 2^14 over 2e
      div_nxt.rem  = num_c[48:15];
      div_nxt.dvs  = {nf.e, 1'b0};
      div_nxt.bits = {num_c[14:0], 14'd0};
    end else begin
      // dividend min(a, b) * 2^28 over b
      div_nxt.rem  = {1'b0, a2_c[33:1]};
      div_nxt.dvs  = nf.b[33:0];
      div_nxt.bits = {a2_c[0], 28'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_o.ctx.vld <= 1'b0;
    end else if (en) begin
      div_o <= div_nxt;
    end
  end

endmodule

// File: design/scc_div_cell.sv
`timescale 1ns / 1ps
module scc_div_cell import scc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  div_t d_i,
  output div_t d_o
);

  // one restoring step: bring down a dividend bit, trial subtract
  logic [34:0] r2_c, diff_c;
  logic        ge_c;
  div_t        d_nxt;

  always_comb begin
    r2_c   = {d_i.rem, d_i.bits[28]};
    diff_c = r2_c - {1'b0, d_i.dvs};
    ge_c   = (r2_c >= {1'b0, d_i.dvs});
    d_nxt      = d_i;
    d_nxt.rem  = ge_c ? diff_c[33:0] : r2_c[33:0];
    d_nxt.bits = {d_i.bits[27:0], ge_c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_o.ctx.vld <= 1'b0;
    end else if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule

// File: design/scc_sqrt_cell.sv
`timescale 1ns / 1ps
module scc_sqrt_cell import scc_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  sq_t  s_i,
  output sq_t  s_o
);

  localparam int unsigned POS = 2 * (SQRT_STEPS - 1 - STEP);

  // one digit of the bitwise integer square root
  logic [28:0] bitv;
  logic [29:0] sum_c;
  sq_t         s_nxt;

  always_comb begin
    bitv  = 29'(1) << POS;
    sum_c = {1'b0, s_i.res} + {1'b0, bitv};
    s_nxt = s_i;
    if ({1'b0, s_i.x} >= sum_c) begin
      s_nxt.x   = s_i.x - sum_c[28:0];
      s_nxt.res = (s_i.res >> 1) + bitv;
    end else begin
      s_nxt.res = s_i.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_o.ctx.vld <= 1'b0;
    end else if (en) begin
      s_o <= s_nxt;
    end
  end

endmodule

// File: design/stereo_bin_correlation_top.sv
`timescale 1ns / 1ps
// Stereo bin correlation: one left/right FFT bin pair in, one Q1.14 value out.
// Input channel: in_valid/in_ready carry the four signed 16-bit bin parts.
// Output channel: out_valid/out_ready carry out_correlation, -16384..16384.
// cfg_we/cfg_wdata write the 2-bit mode (0 normalized, 1 frequency, 2 signed,
// 3 acts as normalized); write it only while no bin is in flight.
// From input transfer to out_valid a bin passes through 9 front stages
// (products, sums, 32x32 multiplies, five normalizing shifts, divider setup),
// 29 restoring divider cells, 15 square-root cells and the output register.
// Throughput is one bin per cycle while the skid entry is empty; every cell hands its state on each enabled cycle.
// Signed mode reuses the same divider chain and skips the root result.
// Reset clears all valid bits and sets the mode to normalized; no bin is
// pending after reset. When the receiver stalls, results fill the output
// register and then a one-entry skid register; input keeps being accepted
// until the skid entry fills, then the whole chain holds and in_ready
// drops for as long as the skid entry is full.
module stereo_bin_correlation_top import scc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_left_re,
  input  logic signed [15:0] in_left_im,
  input  logic signed [15:0] in_right_re,
  input  logic signed [15:0] in_right_im,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_correlation,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata
);

  logic [1:0]         mode_r;
  logic               out_vld_r, skid_vld_r;
  logic signed [15:0] out_r, skid_r;
  logic               en, in_fire;

  assign en       = !skid_vld_r;
  assign in_ready = en;
  assign in_fire  = in_valid && in_ready;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORM;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // front end
  div_t div_s [0:DIV_STEPS];

  scc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_fire  (in_fire),
    .left_re  (in_left_re),
    .left_im  (in_left_im),
    .right_re (in_right_re),
    .right_im (in_right_im),
    .mode     (mode_r),
    .div_o    (div_s[0])
  );

  // divider chain
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    scc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (div_s[i]),
      .d_o   (div_s[i+1])
    );
  end

  // square root chain on the quotient
  sq_t sq_s [0:SQRT_STEPS];

  always_comb begin
    sq_s[0].ctx = div_s[DIV_STEPS].ctx;
    sq_s[0].x   = div_s[DIV_STEPS].bits;
    sq_s[0].res = '0;
    sq_s[0].q2  = div_s[DIV_STEPS].bits[28:14];
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    scc_sqrt_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .s_i   (sq_s[k]),
      .s_o   (sq_s[k+1])
    );
  end

  // rounding, saturation, sign and special cases
  sq_t                sf;
  logic [15:0]        qr_c, q2_c, mag_c;
  logic signed [15:0] res_c;
  logic               push;

  always_comb begin
    sf   = sq_s[SQRT_STEPS];
    qr_c = {1'b0, sf.res[14:0]} + 16'((sf.x > sf.res) ? 1 : 0);
    if (qr_c > 16'(Q_ONE)) qr_c = 16'(Q_ONE);
    q2_c = {1'b0, sf.q2};
    if (q2_c > 16'(Q_ONE)) q2_c = 16'(Q_ONE);
    mag_c = (sf.ctx.mode == MODE_SIGNED) ? q2_c : qr_c;
    if (sf.ctx.spec) begin
      res_c = sf.ctx.spec_one ? 16'(Q_ONE) : 16'sd0;
    end else if (sf.ctx.neg && sf.ctx.mode != MODE_FREQ) begin
      res_c = -$signed(mag_c);
    end else begin
      res_c = $signed(mag_c);
    end
    push = en && sf.ctx.vld;
  end

  // output register plus skid entry
  logic pop;
  assign pop = out_vld_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_vld_r) begin
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r <= push;
        end
      end else if (push) begin
        if (out_vld_r) begin
          skid_vld_r <= 1'b1;
        end else begin
          out_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= res_c;
      end
    end else if (push) begin
      if (out_vld_r) begin
        skid_r <= res_c;
      end else begin
        out_r <= res_c;
      end
    end
  end

  assign out_valid       = out_vld_r;
  assign out_correlation = out_r;

  // checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held without an output transfer pending");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r <= 16'sd16384) && (out_r >= -16'sd16384))
    else $error("correlation out of range");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_vld_r && !skid_vld_r)
    else $error("result pending right after reset");

endmodule
